FILE: rtl/evs_pkg.sv
package evs_pkg;

  localparam int RING_DEPTH = 262144;

  localparam int THR_W  = 41;
  localparam int FLEN_W = 11;
  localparam int SIL_W  = 16;
  localparam int PRE_W  = 18;
  localparam int POS_W  = 18;
  localparam int ID_W   = 16;
  localparam int SMP_W  = 16;
  localparam int SQ_W   = 31;

  localparam logic [THR_W-1:0]  THR_RESET  = 41'd2684354560;
  localparam logic [FLEN_W-1:0] FLEN_RESET = 11'd256;
  localparam logic [SIL_W-1:0]  SIL_RESET  = 16'd62;
  localparam logic [PRE_W-1:0]  PRE_RESET  = 18'd8000;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_FRAME_LEN   = 2'd1,
    REG_SIL_LIMIT   = 2'd2,
    REG_PRE_SPEECH  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_REC  = 2'd1,
    PH_SIL  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                    opcode;
    logic signed [SMP_W-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] seg_start;
    logic [POS_W-1:0] seg_length;
    logic [ID_W-1:0]  seg_id;
    logic             seg_final;
  } out_t;

endpackage

FILE: rtl/energy_vad_segmenter_top.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+--------------------------------------
// in       | input     | in_valid / in_stall    | in_data  (opcode, sample_value)
// out      | output    | out_valid / out_stall  | out_data (seg_start, seg_length,
//          |           |                        |           seg_id, seg_final)
// cfg      | input     | psel/penable/pready    | paddr, pwdata, prdata (64-bit regs at 8*i)
//
// One transaction is taken every cycle while in_stall is low. The square stage captures it
// at the accepting edge, and the accumulate and phase stage loads the output register from
// the square stage register when the pipeline advances.
// Reset (rst_n low, synchronous) clears all control state and restores register defaults.
// A stalled result holds the output register, and the input side stalls only when the
// square stage holds a transaction while a stalled result occupies the output register.
module energy_vad_segmenter_top
  import evs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Ring position width, and a wider width for pointer arithmetic that also holds
  // the 18-bit pre-speech count and the ring depth itself.
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int MW    = ((PTR_W > PRE_W) ? PTR_W : PRE_W) + 1;

  localparam logic [MW-1:0]    DEPTH_M = MW'(RING_DEPTH);
  localparam logic [PTR_W-1:0] WP_LAST = PTR_W'(RING_DEPTH - 1);

  // Configuration registers.
  logic [THR_W-1:0]  thr_r;
  logic [FLEN_W-1:0] flen_r;
  logic [SIL_W-1:0]  sil_lim_r;
  logic [PRE_W-1:0]  pre_r;

  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RESET;
      flen_r    <= FLEN_RESET;
      sil_lim_r <= SIL_RESET;
      pre_r     <= PRE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_THRESHOLD:  thr_r     <= pwdata[THR_W-1:0];
        REG_FRAME_LEN:  flen_r    <= pwdata[FLEN_W-1:0];
        REG_SIL_LIMIT:  sil_lim_r <= pwdata[SIL_W-1:0];
        REG_PRE_SPEECH: pre_r     <= pwdata[PRE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_THRESHOLD:  prdata = CFG_DATA_W'(thr_r);
      REG_FRAME_LEN:  prdata = CFG_DATA_W'(flen_r);
      REG_SIL_LIMIT:  prdata = CFG_DATA_W'(sil_lim_r);
      REG_PRE_SPEECH: prdata = CFG_DATA_W'(pre_r);
    endcase
  end

  // The pipeline moves whenever the output register is empty or being taken.
  logic adv;
  logic s1_valid_r;
  logic s1_op_r;
  logic [SQ_W-1:0] s1_sq_r;
  logic signed [2*SMP_W-1:0] prod;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign prod     = in_data.sample_value * in_data.sample_value;

  // First stage: capture the transaction and square the sample. The square of a
  // 16-bit signed value is at most 2^30, so 31 bits hold it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r <= in_data.opcode;
      s1_sq_r <= prod[SQ_W-1:0];
    end
  end

  // Second stage state.
  phase_t            phase_r, phase_nxt;
  logic [THR_W-1:0]  sum_r, sum_nxt;
  logic [FLEN_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  start_r, start_nxt;
  logic [SIL_W-1:0]  silent_r, silent_nxt;
  logic [ID_W-1:0]   count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              go;
  logic [THR_W-1:0]  sum_add;
  logic [FLEN_W-1:0] fill_inc, flen_eff;
  logic [PTR_W-1:0]  wp_inc;
  logic              frame_done, speech;
  logic [MW-1:0]     back, wp_m, onset;
  logic [SIL_W-1:0]  silent_inc;
  logic [PTR_W-1:0]  end_pos;
  logic [MW-1:0]     seg_len;
  logic              emit_req, emit_final;

  assign go = s1_valid_r && adv;

  assign sum_add    = sum_r + THR_W'(s1_sq_r);
  assign fill_inc   = fill_r + 1'b1;
  assign flen_eff   = (flen_r == '0) ? FLEN_W'(1) : flen_r;
  assign wp_inc     = (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
  assign frame_done = fill_inc >= flen_eff;
  assign speech     = sum_add > thr_r;
  assign silent_inc = (silent_r == '1) ? silent_r : silent_r + 1'b1;

  // Segment onset: the advanced pointer stepped back by the clamped pre-speech count,
  // wrapping around the ring.
  assign back  = (MW'(pre_r) >= DEPTH_M) ? DEPTH_M - 1'b1 : MW'(pre_r);
  assign wp_m  = MW'(wp_inc);
  assign onset = (wp_m >= back) ? wp_m - back : DEPTH_M - (back - wp_m);

  // A flush closes the segment at the current pointer, a sample at the advanced one.
  assign end_pos = (s1_op_r == OP_FLUSH) ? wp_r : wp_inc;
  assign seg_len = (end_pos >= start_r) ? MW'(end_pos - start_r)
                                        : DEPTH_M - MW'(start_r) + MW'(end_pos);

  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    fill_nxt    = fill_r;
    wp_nxt      = wp_r;
    start_nxt   = start_r;
    silent_nxt  = silent_r;
    emit_req    = 1'b0;
    emit_final  = 1'b0;
    if (s1_op_r == OP_FLUSH) begin
      emit_req   = (phase_r == PH_REC) || (phase_r == PH_SIL);
      emit_final = 1'b1;
      phase_nxt  = PH_WAIT;
      sum_nxt    = '0;
      fill_nxt   = '0;
      silent_nxt = '0;
    end else begin
      sum_nxt  = sum_add;
      fill_nxt = fill_inc;
      wp_nxt   = wp_inc;
      if (frame_done) begin
        sum_nxt  = '0;
        fill_nxt = '0;
        unique case (phase_r)
          PH_WAIT: begin
            if (speech) begin
              start_nxt  = onset[PTR_W-1:0];
              silent_nxt = '0;
              phase_nxt  = PH_REC;
            end
          end
          PH_REC: begin
            if (!speech) begin
              phase_nxt  = PH_SIL;
              silent_nxt = SIL_W'(1);
            end
          end
          default: begin
            if (speech) begin
              phase_nxt  = PH_REC;
              silent_nxt = '0;
            end else begin
              silent_nxt = silent_inc;
              if (silent_inc >= sil_lim_r) begin
                emit_req  = 1'b1;
                phase_nxt = PH_WAIT;
              end
            end
          end
        endcase
      end
    end
  end

  // A zero-length segment is dropped without using up a segment number.
  always_comb begin
    count_nxt          = count_r;
    out_valid_nxt      = out_valid_r;
    out_nxt            = out_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
    end
    if (go && emit_req && (seg_len != '0)) begin
      out_valid_nxt      = 1'b1;
      out_nxt.seg_start  = POS_W'(start_r);
      out_nxt.seg_length = seg_len[POS_W-1:0];
      out_nxt.seg_id     = count_r;
      out_nxt.seg_final  = emit_final;
      count_nxt          = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      sum_r       <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      start_r     <= '0;
      silent_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      if (go) begin
        phase_r  <= phase_nxt;
        sum_r    <= sum_nxt;
        fill_r   <= fill_nxt;
        wp_r     <= wp_nxt;
        start_r  <= start_nxt;
        silent_r <= silent_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/evs_checker.sv
module evs_checker
  import evs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // Segment numbers seen at the port must run without gaps from zero.
  logic [ID_W-1:0] exp_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_id_r <= exp_id_r + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_id_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.seg_id == exp_id_r)
    else $error("segment number out of sequence");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result register is empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind energy_vad_segmenter_top evs_checker u_evs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: bench/testbench.sv
module testbench;
  import evs_pkg::*;

  // Cycles with no accepted transaction on either channel before the run is
  // declared hung. The slowest legitimate gap is a drain plus four register
  // writes, so this leaves a wide margin.
  localparam int QUIET_LIMIT   = 2000;
  // The result register is loaded from the square stage register after its
  // input transaction is taken; the settle wait lets an item that produces no
  // result clear the pipeline before a write.
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int LONG_FRAME    = 100;
  localparam int LONG_TAIL     = 40;
  // Per-sample energy just under full scale.
  localparam int LONG_LEVEL    = 32'h3FFF_0000;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  energy_vad_segmenter_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Items waiting to be sent, and the segment descriptors that the accepted
  // items are known to produce, oldest first.
  in_t  pending_items[$];
  out_t expected_segments[$];
  out_t seg_expected;

  int   mismatches   = 0;
  int   queued_items = 0;
  int   quiet_cycles = 0;
  // While set, neither side inserts idle cycles.
  logic steady_flow  = 1'b0;

  // Register copies kept by the predictor. They start at the reset values.
  logic [THR_W-1:0]  vad_thr   = THR_RESET;
  logic [FLEN_W-1:0] vad_flen  = FLEN_RESET;
  logic [SIL_W-1:0]  vad_sil   = SIL_RESET;
  logic [PRE_W-1:0]  vad_pre   = PRE_RESET;

  // Segmenter state as the predictor tracks it.
  phase_t            vad_phase  = PH_WAIT;
  logic [THR_W-1:0]  vad_energy = '0;
  logic [FLEN_W-1:0] vad_fill   = '0;
  logic [POS_W-1:0]  vad_wp     = '0;
  logic [POS_W-1:0]  vad_start  = '0;
  logic [SIL_W-1:0]  vad_quiet  = '0;
  logic [ID_W-1:0]   vad_count  = '0;

  // Shape of the traffic that the generator builds for the current setting.
  int   gen_flen       = 1;
  int   gen_sil        = 0;
  logic gen_quiet_zero = 1'b0;

  // Closes the open segment. A segment of zero length produces nothing and
  // does not consume an id.
  task automatic close_segment(input logic flushed);
    out_t seg;
    int   len;
    if (vad_wp >= vad_start) begin
      len = int'(vad_wp) - int'(vad_start);
    end else begin
      len = RING_DEPTH - int'(vad_start) + int'(vad_wp);
    end
    if (len != 0) begin
      seg.seg_start  = vad_start;
      seg.seg_length = POS_W'(len);
      seg.seg_id     = vad_count;
      seg.seg_final  = flushed;
      expected_segments.insert(expected_segments.size(), seg);
      vad_count = vad_count + 1'b1;
    end
  endtask

  // Advances the predicted segmenter by one accepted input transaction.
  task automatic advance_vad(input in_t item);
    logic signed [SMP_W:0] wide;
    logic [SMP_W:0]        mag;
    logic [FLEN_W-1:0]     flen_eff;
    logic                  speech;
    int                    back;
    if (item.opcode == OP_FLUSH) begin
      // A flush closes any open segment as final and throws away the partial
      // frame; the ring position and the id counter carry on.
      if (vad_phase != PH_WAIT) close_segment(1'b1);
      vad_phase  = PH_WAIT;
      vad_energy = '0;
      vad_fill   = '0;
      vad_quiet  = '0;
    end else begin
      wide       = {item.sample_value[SMP_W-1], item.sample_value};
      mag        = wide[SMP_W] ? -wide : wide;
      vad_energy = vad_energy + THR_W'(mag) * THR_W'(mag);
      vad_fill   = vad_fill + 1'b1;
      vad_wp     = POS_W'((int'(vad_wp) + 1) % RING_DEPTH);
      // A frame length of zero behaves as one. If the length was lowered
      // below the fill, the frame closes on this sample.
      flen_eff = (vad_flen == '0) ? FLEN_W'(1) : vad_flen;
      if (vad_fill >= flen_eff) begin
        speech     = vad_energy > vad_thr;
        vad_energy = '0;
        vad_fill   = '0;
        case (vad_phase)
          PH_WAIT: begin
            if (speech) begin
              back = (int'(vad_pre) >= RING_DEPTH) ? RING_DEPTH - 1 : int'(vad_pre);
              vad_start = POS_W'((int'(vad_wp) - back + RING_DEPTH) % RING_DEPTH);
              vad_quiet = '0;
              vad_phase = PH_REC;
            end
          end
          PH_REC: begin
            if (!speech) begin
              vad_phase = PH_SIL;
              vad_quiet = SIL_W'(1);
            end
          end
          default: begin
            if (speech) begin
              vad_phase = PH_REC;
              vad_quiet = '0;
            end else begin
              // The limit is only looked at from the second silent frame on.
              if (vad_quiet != '1) vad_quiet = vad_quiet + 1'b1;
              if (vad_quiet >= vad_sil) begin
                close_segment(1'b0);
                vad_phase = PH_WAIT;
              end
            end
          end
        endcase
      end
    end
  endtask

  // Driver: presents the next pending item, holds it while stalled, and hands
  // every accepted transaction to the predictor at the edge that takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_vad(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (steady_flow || $urandom_range(99) >= 6)) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Monitor: every result transaction is matched against the oldest expected
  // segment descriptor. The stall is raised at random to back up the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_segments.size() == 0) begin
          $display("%0t: unexpected segment, expected none, actual start %0d length %0d id %0d",
                   $time, out_data.seg_start, out_data.seg_length, out_data.seg_id);
          mismatches++;
        end else begin
          seg_expected = expected_segments.pop_front();
          check_field("seg_start", 32'(seg_expected.seg_start), 32'(out_data.seg_start));
          check_field("seg_length", 32'(seg_expected.seg_length), 32'(out_data.seg_length));
          check_field("seg_id", 32'(seg_expected.seg_id), 32'(out_data.seg_id));
          check_field("seg_final", 32'(seg_expected.seg_final), 32'(out_data.seg_final));
        end
      end
      out_stall <= !steady_flow && ($urandom_range(99) < 6);
    end
  end

  // Watchdog: a run that stops moving transactions for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write: a setup cycle, then an access cycle. The register
  // takes the data at the edge that ends the access cycle, where the predictor's
  // copy follows. At the falling edge after it the read data must show the new value.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] want;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_THRESHOLD: begin
        vad_thr = value[THR_W-1:0];
        want    = CFG_DATA_W'(value[THR_W-1:0]);
      end
      REG_FRAME_LEN: begin
        vad_flen = value[FLEN_W-1:0];
        want     = CFG_DATA_W'(value[FLEN_W-1:0]);
      end
      REG_SIL_LIMIT: begin
        vad_sil = value[SIL_W-1:0];
        want    = CFG_DATA_W'(value[SIL_W-1:0]);
      end
      default: begin
        vad_pre = value[PRE_W-1:0];
        want    = CFG_DATA_W'(value[PRE_W-1:0]);
      end
    endcase
    @(negedge clk);
    if (pready !== 1'b1 || prdata !== want) begin
      $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
               $time, idx, want, prdata);
      mismatches++;
    end
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic [FLEN_W-1:0] flen,
                           input logic [SIL_W-1:0] sil, input logic [PRE_W-1:0] pre);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_FRAME_LEN, CFG_DATA_W'(flen));
    write_reg(REG_SIL_LIMIT, CFG_DATA_W'(sil));
    write_reg(REG_PRE_SPEECH, CFG_DATA_W'(pre));
    gen_flen       = (flen == '0) ? 1 : int'(flen);
    gen_sil        = int'(sil);
    gen_quiet_zero = (thr == '0);
    // Hand control back on a falling edge so the queue is never filled at the
    // same edge at which the driver pops it.
    @(negedge clk);
  endtask

  // Waits until everything sent has been answered, then lets the pipeline
  // empty of items that produce no result.
  task automatic drain_block();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_segments.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_item(input opcode_t op, input logic [SMP_W-1:0] value);
    in_t item;
    item.opcode       = op;
    item.sample_value = value;
    pending_items.insert(pending_items.size(), item);
    queued_items++;
  endtask

  // Loud samples are well above any threshold the random phases pick, quiet
  // ones well below it; zero is the only quiet level when the threshold is 0.
  function automatic logic [SMP_W-1:0] voice_sample(input logic loud);
    logic [SMP_W-1:0] mag;
    if (loud) begin
      case ($urandom_range(19))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        default: mag = SMP_W'($urandom_range(8192, 32767));
      endcase
    end else if (gen_quiet_zero) begin
      return '0;
    end else begin
      mag = SMP_W'($urandom_range(15));
    end
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic push_frame(input logic loud);
    repeat (gen_flen) push_item(OP_SAMPLE, voice_sample(loud));
  endtask

  // Builds roughly the given number of items. Most of them form utterances:
  // some quiet lead-in, speech frames, then silence that often reaches the
  // hangover limit, now and then broken up by a burst of speech or cut short
  // by a flush. The rest is raw noise and stray flushes.
  task automatic queue_traffic(input int budget);
    int goal;
    int pick;
    int reps;
    goal = queued_items + budget;
    while (queued_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_item(OP_SAMPLE, SMP_W'($urandom));
      end else if (pick < 13) begin
        push_item(OP_FLUSH, SMP_W'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) push_frame(1'b0);
        repeat ($urandom_range(1, 3)) push_frame(1'b1);
        reps = $urandom_range(1, (gen_sil > 5 ? 5 : gen_sil) + 2);
        repeat (reps) begin
          push_frame(1'b0);
          if ($urandom_range(99) < 10) push_frame(1'b1);
        end
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(0, gen_flen))
            push_item(OP_SAMPLE, voice_sample(1'($urandom_range(1))));
          push_item(OP_FLUSH, SMP_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    logic [THR_W-1:0]  thr;
    logic [FLEN_W-1:0] flen;
    logic [SIL_W-1:0]  sil;
    logic [PRE_W-1:0]  pre;
    int                flen_eff;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: two-sample frames, no pre-roll, and a limit of zero, so
    // that two silent frames close a segment.
    configure(41'd1000, 11'd2, 16'd0, 18'd0);
    push_item(OP_FLUSH, 16'h0000);       // flush with nothing open
    push_item(OP_SAMPLE, 16'h7FFF);      // both sample extremes, a speech frame
    push_item(OP_SAMPLE, 16'h8000);
    push_item(OP_FLUSH, 16'hFFFF);       // segment of zero length: nothing comes out
    push_item(OP_SAMPLE, 16'h0000);      // quiet frame while waiting
    push_item(OP_SAMPLE, 16'hFFFF);
    push_item(OP_SAMPLE, 16'h8000);      // speech opens a segment
    push_item(OP_SAMPLE, 16'h0001);
    push_item(OP_SAMPLE, 16'h0000);      // first silent frame
    push_item(OP_SAMPLE, 16'h0000);
    push_item(OP_SAMPLE, 16'h0000);      // second silent frame closes it
    push_item(OP_SAMPLE, 16'h0001);
    push_item(OP_SAMPLE, 16'd12345);     // new segment
    push_item(OP_SAMPLE, -16'sd12345);
    push_item(OP_SAMPLE, 16'h0000);      // silence...
    push_item(OP_SAMPLE, 16'h0000);
    push_item(OP_SAMPLE, 16'd30000);     // ...interrupted by speech
    push_item(OP_SAMPLE, -16'sd30000);
    push_item(OP_SAMPLE, 16'h0005);      // partial frame, then flush: final segment
    push_item(OP_FLUSH, 16'h1234);
    push_item(OP_SAMPLE, 16'h7FFF);      // partial frame dropped by a flush while waiting
    push_item(OP_FLUSH, 16'h0000);
    drain_block();

    // Random part: a new setting per phase, most of them pushing a register
    // to an extreme.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      flen = FLEN_W'($urandom_range(2, 12));
      sil  = SIL_W'($urandom_range(0, 5));
      pre  = ($urandom_range(3) == 0) ? PRE_W'($urandom) : PRE_W'($urandom_range(0, 40));
      case (p)
        0: pre = '1;                     // deepest pre-roll the ring allows
        1: begin
          pre = '0;
          sil = '1;                      // hangover never expires; flushes close
        end
        3: flen = '0;
        5: flen = FLEN_W'(1);
        6: sil = '0;
        7: sil = SIL_W'(1);
        default: ;
      endcase
      flen_eff = (flen == '0) ? 1 : int'(flen);
      thr = (p == 2) ? '0 : THR_W'(flen_eff) * THR_W'($urandom_range(1000, 60000000));
      configure(thr, flen, sil, pre);
      steady_flow = (p == 4);
      queue_traffic(PHASE_ITEMS / 2);
      // Hold the sender back until every descriptor is in, at least once.
      if (p == 0 || $urandom_range(1) == 1) drain_block();
      queue_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
      drain_block();
    end
    steady_flow = 1'b0;

    // A longer frame against a threshold just under full scale: only
    // full-scale samples over a whole frame beat it. The trailing partial
    // frame is left open.
    configure(THR_W'(LONG_FRAME) * THR_W'(LONG_LEVEL), FLEN_W'(LONG_FRAME), SIL_W'(1),
              PRE_W'($urandom_range(0, 5000)));
    repeat (LONG_FRAME / 2) begin
      push_item(OP_SAMPLE, 16'h8000);
      push_item(OP_SAMPLE, 16'h7FFF);
    end
    push_item(OP_SAMPLE, 16'h8000);
    repeat (LONG_TAIL) push_item(OP_SAMPLE, 16'h8000);
    drain_block();

    // Frame length dropped below the open frame's fill: the next sample ends
    // that frame. Then ordinary traffic closed by a flush.
    configure(THR_W'(3000), FLEN_W'(3), SIL_W'(2), PRE_W'($urandom_range(0, 20)));
    queue_traffic(30);
    push_item(OP_FLUSH, 16'h0000);
    drain_block();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/evs_pkg.sv
rtl/energy_vad_segmenter_top.sv
rtl/evs_checker.sv
bench/testbench.sv
